/* rtl/dlfg_pkg.sv */
`default_nettype none

package dlfg_pkg;

  localparam int NumDrivers        = 5;
  localparam int ChannelsPerDriver = 16;
  localparam int GrayBits          = 12;
  localparam int NumLeds           = NumDrivers * ChannelsPerDriver;
  localparam int WordBits          = 64;
  localparam int FrameWords        = (NumLeds * GrayBits + WordBits - 1) / WordBits;

  // commands carried in tuser
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_LEVEL = 1'b1;

  // stopwatch modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_RUN  = 2'd1;
  localparam logic [1:0] MODE_STOP = 2'd2;

  // dial styles
  localparam logic [1:0] STYLE_NONE = 2'd0;
  localparam logic [1:0] STYLE_UP   = 2'd1;
  localparam logic [1:0] STYLE_DOWN = 2'd2;

  // register indexes
  localparam logic [2:0] REG_RING_STYLE = 3'd0;
  localparam logic [2:0] REG_IND_EN     = 3'd1;
  localparam logic [2:0] REG_TEST_MODE  = 3'd2;
  localparam logic [2:0] REG_BLUE       = 3'd3;
  localparam logic [2:0] REG_GREEN      = 3'd4;
  localparam logic [2:0] REG_YELLOW     = 3'd5;
  localparam logic [2:0] REG_RED        = 3'd6;

  // dial positions
  localparam logic [6:0] LedHoldFirst = 7'd77;
  localparam logic [6:0] IndFirst     = 7'd61;
  localparam logic [6:0] IndLast      = 7'd64;
  localparam logic [6:0] LedMinute    = 7'd60;
  localparam logic [6:0] LedBlue      = 7'd61;
  localparam logic [6:0] LedGreen     = 7'd62;
  localparam logic [6:0] LedYellow    = 7'd63;
  localparam logic [3:0] BlueBit      = 4'd4;
  localparam logic [3:0] FlagBit      = 4'd2;
  localparam logic [5:0] MaxSecond    = 6'd59;

  // runner arithmetic: q = (ms * MsRecip) >> MsShift is exact for 32-bit ms,
  // runner = ((rem * RunMul) >> RunShift) + 1 equals rem * 3 / 50 + 1
  localparam logic [31:0] MsRecip  = 32'd2199023256;
  localparam int          MsShift  = 41;
  localparam logic [9:0]  MsPerSec = 10'd1000;
  localparam logic [11:0] RunMul   = 12'd3933;
  localparam int          RunShift = 16;

  typedef struct packed {
    logic [1:0] ring_style;
    logic       ind_en;
    logic       test_mode;
    logic       blue;
    logic       green;
    logic       yellow;
    logic       red;
  } cfg_t;

  typedef struct packed {
    logic [5:0] sec;
    logic       sw_active;
    logic [5:0] runner;
    logic [3:0] bright;
  } frame_t;

  typedef struct packed {
    logic                valid;
    logic [WordBits-1:0] word;
    logic [3:0]          idx;
    logic                last;
  } slot_t;

  function automatic logic led_lit(input int n, input int k, input frame_t f, input cfg_t c);
    logic [6:0] nn;
    logic [6:0] ss;
    logic [3:0] kk;
    logic       atb;
    logic       res;
    nn  = 7'(n);
    kk  = 4'(k);
    ss  = {1'b0, f.sec};
    atb = (kk == f.bright);
    if (c.test_mode) begin
      res = atb;
    end else if (f.sw_active) begin
      res = atb && (nn == {1'b0, f.runner} || nn >= LedHoldFirst);
    end else if (c.ring_style == STYLE_UP && atb &&
                 (nn <= ss || nn == LedMinute || nn > IndLast)) begin
      res = 1'b1;
    end else if (c.ring_style == STYLE_DOWN && atb && nn >= ss &&
                 (nn < IndFirst || nn > IndLast) &&
                 !(nn < LedMinute && f.sec == 6'd0)) begin
      res = 1'b1;
    end else if (nn >= IndFirst && nn <= IndLast) begin
      case (nn)
        LedBlue:   res = c.ind_en && kk == BlueBit && c.blue;
        LedGreen:  res = c.ind_en && kk == FlagBit && c.green;
        LedYellow: res = c.ind_en && kk == FlagBit && c.yellow;
        default:   res = c.ind_en && kk == FlagBit && c.red;
      endcase
    end else begin
      res = 1'b0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/dial_led_frame_generator_top.sv */
// Frame generator for an 80-LED dial on five 16-channel drivers, 12 grey bits each.
// Input stream: in_tuser selects the command, 0 renders a frame, 1 sets the light level.
// A set-level transaction produces nothing on the output.
// A frame transaction produces fifteen 64-bit words on the output stream,
// first-shifted bit in bit 63, word index beside it, tlast on the final word.
// Configuration writes arrive on the cfg channel (index, data) and are always ready.
// The first word of a frame is valid once its transaction has passed
// three arithmetic stages for the stopwatch runner, then a parallel load of the chain.
// Throughput: one word per cycle while out_tready is high, set by the 15-cell word chain
// that loads a whole frame at once and moves one cell toward the output on each shift.
// A new frame loads in the cycle the previous frame's last word leaves, so frames
// follow each other with no gap while the receiver keeps out_tready high.
// When the receiver stalls the chain holds; up to three further frames wait in the
// arithmetic stages, then in_tready drops.
// Reset clears the registers, the brightness bit position and the runner position
// to zero and empties the chain; no memory needs clearing.
`default_nettype none

module dial_led_frame_generator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // light_level[3:0], seconds[9:4], stopwatch_mode[11:10], elapsed_ms[43:12]
  input  logic [47:0] in_tdata,
  // cmd[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // frame_word[63:0], word_index[67:64]
  output logic [71:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [1:0]  cfg_data
);
  import dlfg_pkg::*;

  cfg_t                  cfg_r;
  frame_t                desc;
  logic                  desc_valid;
  logic                  shift, load;
  slot_t                 slots    [FrameWords];
  slot_t                 chain_in [FrameWords];
  logic [FrameWords-1:0] cell_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RING_STYLE: cfg_r.ring_style <= cfg_data;
        REG_IND_EN:     cfg_r.ind_en     <= cfg_data[0];
        REG_TEST_MODE:  cfg_r.test_mode  <= cfg_data[0];
        REG_BLUE:       cfg_r.blue       <= cfg_data[0];
        REG_GREEN:      cfg_r.green      <= cfg_data[0];
        REG_YELLOW:     cfg_r.yellow     <= cfg_data[0];
        REG_RED:        cfg_r.red        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  dlfg_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_cmd     (in_tuser),
    .in_level   (in_tdata[3:0]),
    .in_sec     (in_tdata[9:4]),
    .in_mode    (in_tdata[11:10]),
    .in_ms      (in_tdata[43:12]),
    .desc_valid (desc_valid),
    .desc_take  (load),
    .desc       (desc)
  );

  // chain moves whenever the head is empty or being taken
  assign shift = !slots[0].valid || out_tready;
  // a new frame loads once the head holds at most the word now leaving
  assign load  = desc_valid && shift && !slots[1].valid;

  for (genvar i = 0; i < FrameWords; i++) begin : g_cell
    if (i == FrameWords - 1) begin : g_tail
      assign chain_in[i] = '0;
    end else begin : g_link
      assign chain_in[i] = slots[i+1];
    end

    dlfg_cell #(
      .WordIdx (i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .load  (load),
      .shift (shift),
      .frame (desc),
      .cfg   (cfg_r),
      .nb    (chain_in[i]),
      .slot  (slots[i])
    );

    assign cell_valid[i] = slots[i].valid;
  end

  assign out_tvalid = slots[0].valid;
  assign out_tdata  = {4'b0, slots[0].idx, slots[0].word};
  assign out_tlast  = slots[0].last;

  // occupied cells always form a run starting at the head
  a_chain_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot({1'b0, cell_valid} + {{FrameWords{1'b0}}, 1'b1}))
    else $error("word chain has a gap");

  a_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> cell_valid[FrameWords-1] && slots[0].idx == 4'd0)
    else $error("chain load did not fill every cell");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (slots[0].idx == 4'(FrameWords - 1))))
    else $error("last word flag does not match word index");

endmodule

`default_nettype wire

/* rtl/dlfg_prep.sv */
`default_nettype none

module dlfg_prep (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic [3:0]          in_level,
  input  logic [5:0]          in_sec,
  input  logic [1:0]          in_mode,
  input  logic [31:0]         in_ms,
  output logic                desc_valid,
  input  logic                desc_take,
  output dlfg_pkg::frame_t    desc
);
  import dlfg_pkg::*;

  typedef struct packed {
    logic [5:0] sec;
    logic       run;
    logic       sw;
    logic [3:0] bright;
  } item_t;

  logic                v1_r, v2_r, v3_r;
  item_t               it_in, it1_r, it2_r;
  frame_t              desc_r;
  logic [63-MsShift:0] q_r;
  logic [9:0]          ms_lo_r;
  logic [9:0]          rem_r;
  logic [3:0]          bright_r, bright_nxt;
  logic [5:0]          runner_r, runner_nxt, runner_calc;
  logic                en1, en2, en3, acc, frame_acc;
  logic [63:0]         ms_prod;
  logic [19:0]         qk;
  logic [21:0]         run_prod;

  assign en3       = !v3_r || desc_take;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_ready  = en1;
  assign acc       = in_valid && in_ready;
  assign frame_acc = acc && (in_cmd == CMD_FRAME);

  // set-level decode
  always_comb begin
    unique case (in_level)
      4'd0:    bright_nxt = 4'd5;
      4'd1:    bright_nxt = 4'd4;
      4'd2:    bright_nxt = 4'd3;
      4'd3:    bright_nxt = 4'd1;
      4'd4:    bright_nxt = 4'd0;
      default: bright_nxt = bright_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r <= 4'd0;
    end else if (acc && in_cmd == CMD_LEVEL) begin
      bright_r <= bright_nxt;
    end
  end

  always_comb begin
    it_in.sec    = (in_sec > MaxSecond) ? MaxSecond : in_sec;
    it_in.run    = (in_mode == MODE_RUN);
    it_in.sw     = (in_mode == MODE_RUN) || (in_mode == MODE_STOP);
    it_in.bright = bright_r;
  end

  // stage 1: quotient of ms by 1000 through the reciprocal
  assign ms_prod = in_ms * MsRecip;

  // stage 2: remainder, only the low ten bits matter
  assign qk = q_r[9:0] * MsPerSec;

  // stage 3: runner position
  assign run_prod    = rem_r * RunMul;
  assign runner_calc = 6'(run_prod >> RunShift) + 6'd1;
  assign runner_nxt  = it2_r.run ? runner_calc : runner_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      runner_r <= 6'd0;
    end else begin
      if (en1) v1_r <= frame_acc;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en3 && v2_r) runner_r <= runner_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      it1_r   <= it_in;
      q_r     <= ms_prod[63:MsShift];
      ms_lo_r <= in_ms[9:0];
    end
    if (en2) begin
      it2_r <= it1_r;
      rem_r <= ms_lo_r - qk[9:0];
    end
    if (en3) begin
      desc_r.sec       <= it2_r.sec;
      desc_r.sw_active <= it2_r.sw;
      desc_r.runner    <= runner_nxt;
      desc_r.bright    <= it2_r.bright;
    end
  end

  assign desc_valid = v3_r;
  assign desc       = desc_r;

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> rem_r < MsPerSec)
    else $error("remainder out of range");

  a_runner_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> desc_r.runner <= LedMinute[5:0])
    else $error("runner position out of range");

  a_runner_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(runner_r) |-> $past(en3 && v2_r && it2_r.run))
    else $error("runner changed without a running frame");

endmodule

`default_nettype wire

/* rtl/dlfg_cell.sv */
`default_nettype none

module dlfg_cell #(
  parameter int WordIdx = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic             shift,
  input  dlfg_pkg::frame_t frame,
  input  dlfg_pkg::cfg_t   cfg,
  input  dlfg_pkg::slot_t  nb,
  output dlfg_pkg::slot_t  slot
);
  import dlfg_pkg::*;

  logic                valid_r;
  logic [WordBits-1:0] word_r;
  logic [3:0]          idx_r;
  logic                last_r;
  logic [WordBits-1:0] gen_word;

  // frame bit p sits at word p / 64, bit 63 - p % 64; channel p / 12 drives led 80 - channel
  for (genvar b = 0; b < WordBits; b++) begin : g_bit
    localparam int P   = WordIdx * WordBits + b;
    localparam int Ch  = P / GrayBits;
    localparam int Kb  = P % GrayBits;
    localparam int Led = NumLeds - Ch;
    assign gen_word[WordBits-1-b] = led_lit(Led, Kb, frame, cfg);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (shift) begin
      valid_r <= nb.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= gen_word;
      idx_r  <= 4'(WordIdx);
      last_r <= (WordIdx == FrameWords - 1);
    end else if (shift) begin
      word_r <= nb.word;
      idx_r  <= nb.idx;
      last_r <= nb.last;
    end
  end

  assign slot.valid = valid_r;
  assign slot.word  = word_r;
  assign slot.idx   = idx_r;
  assign slot.last  = last_r;

endmodule

`default_nettype wire

/* tb/dial_frame_checker.sv */
`default_nettype none

module dial_frame_checker
  import dlfg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  // light_level[3:0], seconds[9:4], stopwatch_mode[11:10], elapsed_ms[43:12]
  input  wire logic [47:0] in_tdata,
  // cmd[0]
  input  wire logic        in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  // frame_word[63:0], word_index[67:64]
  input  wire logic [71:0] out_tdata,
  input  wire logic        out_tlast,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [1:0]  cfg_data,
  output int               words_pending,
  output int               mismatch_count,
  output int               words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FrameBits   = FrameWords * WordBits;
  localparam int HoldFrom    = int'(LedHoldFirst);
  localparam int FlagFrom    = int'(IndFirst);
  localparam int FlagTo      = int'(IndLast);
  localparam int MinuteLed   = int'(LedMinute);

  typedef struct packed {
    logic [WordBits-1:0] word;
    logic [3:0]          index;
    logic                last;
  } frame_word_t;

  frame_word_t         word_q[$];
  frame_word_t         want;
  cfg_t                dial_cfg;
  logic [3:0]          brightness;
  logic [5:0]          runner;
  logic [FrameBits-1:0] frame_bits;
  logic [31:0]         ms;
  logic [1:0]          sw_mode;
  logic                sw_on;
  int                  sec;
  int                  mismatches;
  int                  checked;

  // one grey bit of one led, first matching rule wins
  function automatic logic led_on(input int led, input int k, input int sec_now,
                                  input logic sw_shown);
    logic at_level;
    logic flag_led;
    at_level = (k == int'(brightness));
    flag_led = (led >= FlagFrom && led <= FlagTo);
    if (dial_cfg.test_mode) return at_level;
    if (sw_shown) return at_level && (led == int'(runner) || led >= HoldFrom);
    if (dial_cfg.ring_style == STYLE_UP && at_level &&
        (led <= sec_now || led == MinuteLed || led > FlagTo)) return 1'b1;
    if (dial_cfg.ring_style == STYLE_DOWN && at_level && led >= sec_now && !flag_led &&
        !(led < MinuteLed && sec_now == 0)) return 1'b1;
    if (!flag_led || !dial_cfg.ind_en) return 1'b0;
    if (led == int'(LedBlue)) return k == int'(BlueBit) && dial_cfg.blue;
    if (led == int'(LedGreen)) return k == int'(FlagBit) && dial_cfg.green;
    if (led == int'(LedYellow)) return k == int'(FlagBit) && dial_cfg.yellow;
    return k == int'(FlagBit) && dial_cfg.red;
  endfunction

  task automatic note_mismatch(input string field, input logic [63:0] exp_val,
                               input logic [63:0] got_val);
    $error("%s: expected %h, got %h", field, exp_val, got_val);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      word_q.delete();
      dial_cfg   = '0;
      brightness = '0;
      runner     = '0;
      mismatches = 0;
      checked    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RING_STYLE: dial_cfg.ring_style = cfg_data;
          REG_IND_EN:     dial_cfg.ind_en     = cfg_data[0];
          REG_TEST_MODE:  dial_cfg.test_mode  = cfg_data[0];
          REG_BLUE:       dial_cfg.blue       = cfg_data[0];
          REG_GREEN:      dial_cfg.green      = cfg_data[0];
          REG_YELLOW:     dial_cfg.yellow     = cfg_data[0];
          REG_RED:        dial_cfg.red        = cfg_data[0];
          default: ;
        endcase
      end

      // outputs first, so a word can never match an expectation made this same edge
      if (out_tvalid && out_tready) begin
        checked++;
        if (word_q.size() == 0) begin
          $error("frame_word: expected no word, got %h index %0d",
                 out_tdata[63:0], out_tdata[67:64]);
          mismatches++;
        end else begin
          want = word_q.pop_front();
          if (out_tdata[63:0] != want.word)
            note_mismatch("frame_word", want.word, out_tdata[63:0]);
          if (out_tdata[67:64] != want.index)
            note_mismatch("word_index", 64'(want.index), 64'(out_tdata[67:64]));
          if (out_tlast != want.last)
            note_mismatch("last_word", 64'(want.last), 64'(out_tlast));
        end
      end

      if (in_tvalid && in_tready) begin
        if (in_tuser == CMD_LEVEL) begin
          case (in_tdata[3:0])
            4'd0: brightness = 4'd5;
            4'd1: brightness = 4'd4;
            4'd2: brightness = 4'd3;
            4'd3: brightness = 4'd1;
            4'd4: brightness = 4'd0;
            default: ;
          endcase
        end else begin
          sec     = (in_tdata[9:4] > MaxSecond) ? int'(MaxSecond) : int'(in_tdata[9:4]);
          sw_mode = in_tdata[11:10];
          ms      = in_tdata[43:12];
          sw_on   = (sw_mode == MODE_RUN || sw_mode == MODE_STOP);
          // runner only moves while running, held when stopped
          if (sw_mode == MODE_RUN)
            runner = 6'((ms % 32'd1000) * 32'd3 / 32'd50 + 32'd1);
          frame_bits = '0;
          // channel ch drives led NumLeds - ch, shift position ch*GrayBits + k
          for (int ch = 0; ch < NumLeds; ch++)
            for (int k = 0; k < GrayBits; k++)
              if (led_on(NumLeds - ch, k, sec, sw_on))
                frame_bits[FrameBits - 1 - (ch * GrayBits + k)] = 1'b1;
          for (int w = 0; w < FrameWords; w++)
            word_q.push_back('{word:  frame_bits[(FrameWords - 1 - w) * WordBits +: WordBits],
                               index: 4'(w),
                               last:  (w == FrameWords - 1)});
        end
      end
    end
    words_pending  <= word_q.size();
    mismatch_count <= mismatches;
    words_checked  <= checked;
  end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dlfg_pkg::*;

  localparam int QuietLimit   = 2000;
  localparam int SettleCycles = 10;
  localparam int PhaseItems   = 51;
  localparam int NumPhases    = 6;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = '0;
  logic [1:0]  cfg_data   = '0;

  int words_pending;
  int mismatch_count;
  int words_checked;

  int frames_sent;
  int levels_sent;
  int settings_loaded;
  int burst_left;
  int gap_style;
  int ready_cycle  = 0;
  int quiet_cycles = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  dial_led_frame_generator_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dial_frame_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .words_pending (words_pending),
    .mismatch_count(mismatch_count),
    .words_checked (words_checked)
  );

  // receiver back-pressure cycles through always-ready, light stalls, heavy stalls and rare readiness
  always @(posedge clk) begin
    ready_cycle <= ready_cycle + 1;
    case ((ready_cycle / 300) % 4)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ((ready_cycle % 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("no transaction for %0d cycles", QuietLimit);
        $display("dial_led_frame_generator_top test failed");
        $finish;
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [3:0] level, input logic [5:0] sec,
                           input logic [1:0] mode, input logic [31:0] ms);
    if (burst_left == 0) begin
      if (gap_style != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, (gap_style == 1) ? 3 : 20)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0, ms, mode, sec, level};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == CMD_FRAME) frames_sent++;
    else levels_sent++;
  endtask

  task automatic frame_item(input logic [5:0] sec, input logic [1:0] mode,
                            input logic [31:0] ms);
    send_item(CMD_FRAME, 4'($urandom_range(0, 15)), sec, mode, ms);
  endtask

  task automatic level_item(input logic [3:0] level);
    send_item(CMD_LEVEL, level, 6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)),
              $urandom());
  endtask

  // drain every frame in flight, then give set-level commands time to land
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // upper data bit of the one-bit registers is noise
  task automatic load_settings(input logic [1:0] style, input logic ind, test, blue, green,
                               yellow, red);
    write_reg(REG_RING_STYLE, style);
    write_reg(REG_IND_EN, {1'($urandom_range(0, 1)), ind});
    write_reg(REG_TEST_MODE, {1'($urandom_range(0, 1)), test});
    write_reg(REG_BLUE, {1'($urandom_range(0, 1)), blue});
    write_reg(REG_GREEN, {1'($urandom_range(0, 1)), green});
    write_reg(REG_YELLOW, {1'($urandom_range(0, 1)), yellow});
    write_reg(REG_RED, {1'($urandom_range(0, 1)), red});
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  task automatic random_item();
    int pick;
    int mode_pick;
    logic [1:0] mode;
    logic [5:0] sec;
    logic [31:0] ms;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      level_item(4'($urandom_range(0, (pick < 18) ? 4 : 15)));
    end else begin
      mode_pick = $urandom_range(0, 9);
      if (mode_pick < 3) mode = MODE_IDLE;
      else if (mode_pick < 6) mode = MODE_RUN;
      else if (mode_pick < 9) mode = MODE_STOP;
      else mode = 2'd3;
      sec = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(60, 63))
                                        : 6'($urandom_range(0, 59));
      ms = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 2999);
      frame_item(sec, mode, ms);
    end
  endtask

  initial begin
    frames_sent     = 0;
    levels_sent     = 0;
    settings_loaded = 0;
    burst_left      = 0;
    gap_style       = 1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: dark dial, stopwatch runner arithmetic and its hold
    frame_item(6'd0, MODE_IDLE, 32'd0);
    frame_item(6'd59, MODE_RUN, 32'd0);
    level_item(4'd2);
    level_item(4'd15);
    frame_item(6'd63, MODE_STOP, 32'd999);
    frame_item(6'd0, MODE_RUN, 32'hFFFF_FFFF);
    frame_item(6'd30, MODE_RUN, 32'd999);
    frame_item(6'd30, 2'd3, 32'd500);

    settle();
    load_settings(STYLE_UP, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
    level_item(4'd0);
    frame_item(6'd0, MODE_IDLE, $urandom());
    frame_item(6'd59, MODE_IDLE, $urandom());
    frame_item(6'd63, MODE_IDLE, $urandom());
    frame_item(6'd20, MODE_STOP, $urandom());

    settle();
    load_settings(STYLE_DOWN, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
    frame_item(6'd0, MODE_IDLE, 32'd0);
    frame_item(6'd1, MODE_IDLE, 32'd0);
    // brightness lands on the blue indicator bit
    level_item(4'd1);
    frame_item(6'd59, MODE_IDLE, 32'd0);
    frame_item(6'd60, MODE_IDLE, 32'd0);
    level_item(4'd3);
    frame_item(6'd30, MODE_IDLE, 32'd0);

    settle();
    // unused dial style falls back to no ring
    load_settings(2'd3, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
    level_item(4'd4);
    level_item(4'd5);
    frame_item(6'd10, MODE_IDLE, 32'd0);

    settle();
    load_settings(STYLE_UP, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    frame_item(6'd10, MODE_RUN, 32'd12345);

    settle();
    load_settings(STYLE_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    frame_item(6'd45, MODE_IDLE, 32'd0);

    for (int phase = 0; phase < NumPhases; phase++) begin
      settle();
      gap_style = phase % 3;
      if (phase == 0)
        load_settings(STYLE_DOWN, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
      else if (phase == 1)
        load_settings(STYLE_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      else
        load_settings(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      ($urandom_range(0, 4) == 0), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
      for (int i = 0; i < PhaseItems; i++) random_item();
    end

    settle();
    $display("sent %0d frames and %0d level commands under %0d register settings",
             frames_sent, levels_sent, settings_loaded);
    $display("compared %0d frame words, %0d mismatches", words_checked, mismatch_count);
    if (mismatch_count == 0 && words_pending == 0)
      $display("dial_led_frame_generator_top test passed");
    else
      $display("dial_led_frame_generator_top test failed");
    $finish;
  end

endmodule

`default_nettype wire
